// ----- hdl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, disabled during reset.
`define GPL_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// Same-cycle implication check.
`define GPL_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  `GPL_ASSERT(lbl, clk, rst, (ante) |-> (cons), msg)

`endif

// ----- hdl/gpl_pkg.sv -----
package gpl_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int RATIO_BITS      = 24;
  localparam logic [RATIO_BITS-1:0] RATIO_MAX = '1;
  localparam int CFG_IDX_BITS    = 8;
  localparam int CFG_DATA_BITS   = 32;
  localparam int PPM_BITS        = 14;
  localparam logic [PPM_BITS-1:0] PPM_LIMIT = 14'd9999;

  localparam logic [15:0] LOAD_RESET     = 16'd2560;
  localparam logic [15:0] BASELINE_RESET = 16'd2560;
  localparam logic [31:0] SCALE_RESET    = 32'd6490817;
  localparam logic [15:0] EXPONENT_RESET = 16'hE7B6;  // -6218

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_LOAD     = 8'd0,
    REG_BASELINE = 8'd1,
    REG_SCALE    = 8'd2,
    REG_EXPONENT = 8'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SIGNAL = 2'd1,
    ST_OPEN      = 2'd2,
    ST_CLAMPED   = 2'd3
  } status_t;

  // Sideband that rides along the pipeline with each beat.
  typedef struct packed {
    logic               special;
    status_t            code;
    logic signed [9:0]  n;
  } side_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] xr;
    logic [63:0] res;
    logic [63:0] b;
    xr  = x;
    res = '0;
    b   = 64'h4000_0000_0000_0000;
    for (int j = 0; j < 32; j++) begin
      if (xr >= res + b) begin
        xr  = xr - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // 2^(2^-(k+1)) in Q2.30, by repeated truncated square roots from 2.0.
  function automatic logic [31:0] exp2_root(input int k);
    logic [63:0] r;
    r = 64'd2 << 30;
    for (int j = 0; j <= k; j++) begin
      r = isqrt64(r << 30);
    end
    return r[31:0];
  endfunction

endpackage

// ----- hdl/gpl_sample_if.sv -----
interface gpl_sample_if #(
  parameter int SAMPLE_BITS = gpl_pkg::SAMPLE_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

// ----- hdl/gpl_result_if.sv -----
interface gpl_result_if ();
  logic        valid;
  logic        ready;
  logic [13:0] ppm;
  logic [1:0]  status;

  modport source (output valid, output ppm, output status, input ready);
  modport sink   (input valid, input ppm, input status, output ready);
endinterface

// ----- hdl/gpl_cfg_if.sv -----
interface gpl_cfg_if ();
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/gpl_div.sv -----
module gpl_div #(
  parameter int SAMPLE_BITS = gpl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [SAMPLE_BITS+31:0]        num,
  input  logic [SAMPLE_BITS+15:0]        den,
  input  gpl_pkg::side_t                 in_side,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [gpl_pkg::RATIO_BITS-1:0] ratio,
  output gpl_pkg::side_t                 out_side
);
  import gpl_pkg::*;

  localparam int NW = SAMPLE_BITS + 32;
  localparam int DW = SAMPLE_BITS + 16;
  localparam int RW = DW + RATIO_BITS;
  localparam int NS = RATIO_BITS + 1;

  logic [NS-1:0] vld;
  logic [NS-1:0] go;
  logic [NS-1:0] go_nx;
  logic [RW-1:0]         rem [NS];
  logic [DW-1:0]         dv  [NS];
  logic [RATIO_BITS-1:0] q   [NS];
  logic                  ovf [NS];
  side_t                 sd  [NS];

  assign go_nx = {out_ready, go[NS-1:1]};
  assign go    = ~vld | go_nx;
  assign in_ready = go[0];

  for (genvar k = 0; k < NS; k++) begin : g_st
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (go[k]) begin
        vld[k] <= (k == 0) ? in_valid : vld[(k == 0) ? 0 : k-1];
      end
    end

    if (k == 0) begin : g_first
      // saturate when the quotient would not fit in 24 bits
      always_ff @(posedge clk) begin
        if (go[0]) begin
          rem[0] <= RW'(num);
          dv[0]  <= den;
          q[0]   <= '0;
          ovf[0] <= RW'(num) >= {den, {RATIO_BITS{1'b0}}};
          sd[0]  <= in_side;
        end
      end
    end else begin : g_bit
      localparam int SH = NS - 1 - k;
      logic [RW-1:0] trial;
      assign trial = RW'(dv[k-1]) << SH;
      always_ff @(posedge clk) begin
        if (go[k]) begin
          dv[k]  <= dv[k-1];
          ovf[k] <= ovf[k-1];
          sd[k]  <= sd[k-1];
          if (rem[k-1] >= trial) begin
            rem[k] <= rem[k-1] - trial;
            q[k]   <= q[k-1] | (RATIO_BITS'(1) << SH);
          end else begin
            rem[k] <= rem[k-1];
            q[k]   <= q[k-1];
          end
        end
      end
    end
  end

  assign out_valid = vld[NS-1];
  assign out_side  = sd[NS-1];
  always_comb begin
    if (ovf[NS-1]) begin
      ratio = RATIO_MAX;
    end else if (q[NS-1] == '0) begin
      ratio = RATIO_BITS'(1);
    end else begin
      ratio = q[NS-1];
    end
  end

endmodule

// ----- hdl/gpl_log2.sv -----
module gpl_log2 (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [gpl_pkg::RATIO_BITS-1:0] ratio,
  input  gpl_pkg::side_t                 in_side,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [21:0]             lg,
  output gpl_pkg::side_t                 out_side
);
  import gpl_pkg::*;

  localparam int NS = 17;

  logic [NS-1:0] vld;
  logic [NS-1:0] go;
  logic [NS-1:0] go_nx;
  logic [4:0]  p  [NS];
  logic [30:0] m  [NS];
  logic [15:0] fr [NS];
  side_t       sd [NS];

  logic [4:0]  lead;
  logic [30:0] m_init;

  assign go_nx = {out_ready, go[NS-1:1]};
  assign go    = ~vld | go_nx;
  assign in_ready = go[0];

  always_comb begin
    lead = '0;
    for (int j = 0; j < RATIO_BITS; j++) begin
      if (ratio[j]) begin
        lead = 5'(j);
      end
    end
  end

  // normalize to Q1.30
  assign m_init = {7'b0, ratio} << (5'd30 - lead);

  for (genvar k = 0; k < NS; k++) begin : g_st
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (go[k]) begin
        vld[k] <= (k == 0) ? in_valid : vld[(k == 0) ? 0 : k-1];
      end
    end

    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (go[0]) begin
          p[0]  <= lead;
          m[0]  <= m_init;
          fr[0] <= '0;
          sd[0] <= in_side;
        end
      end
    end else begin : g_sq
      localparam int BI = NS - 1 - k;
      logic [61:0] sq;
      logic [31:0] sq30;
      assign sq   = 62'(m[k-1]) * 62'(m[k-1]);
      assign sq30 = sq[61:30];
      always_ff @(posedge clk) begin
        if (go[k]) begin
          p[k]  <= p[k-1];
          sd[k] <= sd[k-1];
          if (sq30[31]) begin
            m[k]  <= sq30[31:1];
            fr[k] <= fr[k-1] | (16'd1 << BI);
          end else begin
            m[k]  <= sq30[30:0];
            fr[k] <= fr[k-1];
          end
        end
      end
    end
  end

  assign out_valid = vld[NS-1];
  assign out_side  = sd[NS-1];
  assign lg = $signed({6'({1'b0, p[NS-1]}) - 6'd16, fr[NS-1]});

endmodule

// ----- hdl/gpl_exp2.sv -----
module gpl_exp2 (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [15:0]    f,
  input  gpl_pkg::side_t in_side,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    acc_out,
  output gpl_pkg::side_t out_side
);
  import gpl_pkg::*;

  localparam int NS = 16;
  localparam logic [31:0] ONE_Q30 = 32'd1 << 30;

  logic [NS-1:0] vld;
  logic [NS-1:0] go;
  logic [NS-1:0] go_nx;
  logic [31:0] acc [NS];
  logic [15:0] fa  [NS];
  side_t       sd  [NS];

  assign go_nx = {out_ready, go[NS-1:1]};
  assign go    = ~vld | go_nx;
  assign in_ready = go[0];

  for (genvar k = 0; k < NS; k++) begin : g_st
    localparam logic [31:0] ROOT = exp2_root(k);
    localparam int BI = NS - 1 - k;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (go[k]) begin
        vld[k] <= (k == 0) ? in_valid : vld[(k == 0) ? 0 : k-1];
      end
    end

    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (go[0]) begin
          acc[0] <= f[BI] ? ROOT : ONE_Q30;
          fa[0]  <= f;
          sd[0]  <= in_side;
        end
      end
    end else begin : g_mul
      logic [63:0] prod;
      assign prod = 64'(acc[k-1]) * 64'(ROOT);
      always_ff @(posedge clk) begin
        if (go[k]) begin
          acc[k] <= fa[k-1][BI] ? prod[61:30] : acc[k-1];
          fa[k]  <= fa[k-1];
          sd[k]  <= sd[k-1];
        end
      end
    end
  end

  assign out_valid = vld[NS-1];
  assign out_side  = sd[NS-1];
  assign acc_out   = acc[NS-1];

endmodule

// ----- hdl/adc_to_gas_ppm_power_law_unit.sv -----
// Gas concentration estimate from a resistive sensor divider sample.
// Channels: sample (sink) takes one adc_sample per beat; result (source)
// gives ppm and status per beat, in order; cfg (sink) writes the load,
// baseline, scale and exponent registers by index, always ready.
// The pipeline runs in order: front multiplies, radix-2 ratio division
// (an overflow check, then one quotient bit per stage), log2 (leading-one
// normalize, then one squaring per fraction bit), one exponent multiply,
// exp2 (one root product per fraction bit), one scale multiply and one
// shift/clamp output stage.
// Throughput is one beat per cycle while the result is not stalled. Each
// stage holds a valid bit and moves on when the stage after it is empty or
// moving, so a stalled result only backs up the beats behind it; bubbles
// ahead of the stall still fill. Reset clears all valid bits and loads the
// register defaults; nothing is cleared in the datapath. Registers should be
// written only while no beat is in flight.
`include "assert_macros.svh"

module adc_to_gas_ppm_power_law_unit #(
  parameter int SAMPLE_BITS = gpl_pkg::SAMPLE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  gpl_sample_if.sink    sample,
  gpl_result_if.source  result,
  gpl_cfg_if.sink       cfg
);
  import gpl_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam logic [SB-1:0] FULL = '1;

  logic [15:0] load_res;
  logic [15:0] base_res;
  logic [31:0] scale;
  logic [15:0] exponent;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_res <= LOAD_RESET;
      base_res <= BASELINE_RESET;
      scale    <= SCALE_RESET;
      exponent <= EXPONENT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_LOAD:     load_res <= cfg.data[15:0];
        REG_BASELINE: base_res <= cfg.data[15:0];
        REG_SCALE:    scale    <= cfg.data;
        REG_EXPONENT: exponent <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  // front stage
  logic            vf, go_f;
  logic [SB+31:0]  num_f;
  logic [SB+15:0]  den_f;
  side_t           sd_f, sd_in;
  logic [SB-1:0]   s;
  logic [15:0]     base_eff;
  logic [SB+15:0]  lprod;
  logic            div_in_ready;

  assign s        = sample.adc_sample;
  assign base_eff = (base_res == '0) ? 16'd1 : base_res;
  assign lprod    = (SB+16)'(load_res) * (SB+16)'(FULL - s);
  assign go_f     = ~vf | div_in_ready;
  assign sample.ready = go_f;

  always_comb begin
    sd_in   = '0;
    if (s == '0) begin
      sd_in.special = 1'b1;
      sd_in.code    = ST_NO_SIGNAL;
    end else if (s == FULL) begin
      sd_in.special = 1'b1;
      sd_in.code    = ST_OPEN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (go_f) begin
      vf <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go_f) begin
      num_f <= {lprod, 16'b0};
      den_f <= (SB+16)'(s) * (SB+16)'(base_eff);
      sd_f  <= sd_in;
    end
  end

  // ratio divider
  logic                  div_vld, log_in_ready;
  logic [RATIO_BITS-1:0] div_ratio;
  side_t                 div_side;

  gpl_div #(.SAMPLE_BITS(SB)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vf),
    .in_ready  (div_in_ready),
    .num       (num_f),
    .den       (den_f),
    .in_side   (sd_f),
    .out_valid (div_vld),
    .out_ready (log_in_ready),
    .ratio     (div_ratio),
    .out_side  (div_side)
  );

  // log2
  logic               log_vld, go_t;
  logic signed [21:0] lg;
  side_t              log_side;

  gpl_log2 u_log2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_vld),
    .in_ready  (log_in_ready),
    .ratio     (div_ratio),
    .in_side   (div_side),
    .out_valid (log_vld),
    .out_ready (go_t),
    .lg        (lg),
    .out_side  (log_side)
  );

  // exponent multiply: t = floor(e*lg/4096), n = floor(t/65536)
  logic               vt, exp_in_ready;
  logic signed [37:0] tp;
  logic [15:0]        f_t;
  side_t              sd_t;

  assign tp   = 38'($signed(exponent)) * 38'(lg);
  assign go_t = ~vt | exp_in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vt <= 1'b0;
    end else if (go_t) begin
      vt <= log_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (go_t) begin
      f_t          <= tp[27:12];
      sd_t.special <= log_side.special;
      sd_t.code    <= log_side.code;
      sd_t.n       <= $signed(tp[37:28]);
    end
  end

  // exp2 of fraction
  logic        exp_vld, go_m;
  logic [31:0] exp_acc;
  side_t       exp_side;

  gpl_exp2 u_exp2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vt),
    .in_ready  (exp_in_ready),
    .f         (f_t),
    .in_side   (sd_t),
    .out_valid (exp_vld),
    .out_ready (go_m),
    .acc_out   (exp_acc),
    .out_side  (exp_side)
  );

  // scale multiply
  logic        vm, go_s;
  logic [63:0] prod_m;
  side_t       sd_m;

  assign go_m = ~vm | go_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (go_m) begin
      vm <= exp_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (go_m) begin
      prod_m <= 64'(scale) * 64'(exp_acc);
      sd_m   <= exp_side;
    end
  end

  // shift by 46-n, clamp, output register
  logic               vs;
  logic [13:0]        ppm_next;
  status_t            status_next;
  logic [13:0]        ppm_q;
  status_t            status_q;
  logic signed [10:0] shs;
  logic [63:0]        shifted;

  assign go_s = ~vs | result.ready;
  assign shs  = 11'sd46 - $signed({sd_m.n[9], sd_m.n});
  assign shifted = prod_m >> shs[5:0];

  always_comb begin
    ppm_next    = '0;
    status_next = ST_OK;
    if (sd_m.special) begin
      status_next = sd_m.code;
    end else if (scale == '0) begin
      ppm_next = '0;
    end else if (shs <= 11'sd0) begin
      ppm_next    = PPM_LIMIT;
      status_next = ST_CLAMPED;
    end else if (shs >= 11'sd64) begin
      ppm_next = '0;
    end else if (shifted > 64'(PPM_LIMIT)) begin
      ppm_next    = PPM_LIMIT;
      status_next = ST_CLAMPED;
    end else begin
      ppm_next = shifted[13:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= 1'b0;
    end else if (go_s) begin
      vs <= vm;
    end
  end

  always_ff @(posedge clk) begin
    if (go_s) begin
      ppm_q    <= ppm_next;
      status_q <= status_next;
    end
  end

  assign result.valid  = vs;
  assign result.ppm    = ppm_q;
  assign result.status = status_q;

  `GPL_ASSERT(a_ppm_range, clk, rst, !result.valid || result.ppm <= PPM_LIMIT, "ppm over limit")
  `GPL_ASSERT_IMPL(a_clamp_value, clk, rst, result.valid && result.status == ST_CLAMPED, result.ppm == PPM_LIMIT, "clamped beat without limit value")
  `GPL_ASSERT_IMPL(a_fault_zero, clk, rst, result.valid && (result.status == ST_NO_SIGNAL || result.status == ST_OPEN), result.ppm == 14'd0, "fault beat with nonzero ppm")
  `GPL_ASSERT_IMPL(a_ratio_nonzero, clk, rst, div_vld, div_ratio != '0, "zero ratio into log2")

endmodule
